[design/cbq_pkg.sv]
// ----------------------------------------------------------------------------
// cbq_pkg: shared definitions of the cascaded biquad filter
// Default sizes, coefficient slot codes, register indexes and the command
// word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package cbq_pkg;

    localparam int DEF_MAX_SECTIONS = 8;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_COEF_BITS    = 18;

    localparam int COEFS_PER_SECTION = 5;
    localparam int SECTION_CFG_BITS  = 4;

    // Integer bits of the coefficient format (Q2.x plus sign).
    localparam int COEF_INT_BITS = 3;
    // Extra integer bits of the delay format over the sample format.
    localparam int DELAY_EXTRA_BITS = 8;

    // Division by five through a reciprocal, exact for values below 1024.
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 1'b1;

    typedef struct packed {
        logic coef_wr;   // store one coefficient from the input word
        logic start;     // capture the input sample
        logic rd_en;     // fetch coefficients and delays of a section
        logic mul1;      // products on the old delays
        logic wsum;      // new w, delay update
        logic mul2;      // b0 * w
        logic ysum;      // section output
        logic gmul;      // gain product
        logic out_load;  // load the output register
    } cbq_cmd_t;

endpackage

[design/cascaded_biquad_iir_filter.sv]
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter: cascade of direct-form-II biquads with gain
// A sample word runs through the sections in use (clamped to MAX_SECTIONS)
// and the gain stage, then waits for the output register to be free; a
// coefficient word is written on acceptance. The single shared section unit,
// where b0*w waits on the new w, takes no new sample until the last is loaded.
// Reset clears the delay registers, sets one section and a gain of 1.0;
// coefficients hold no defined value until written.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter #(
    parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS,
    parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS    = cbq_pkg::DEF_COEF_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [$clog2(cbq_pkg::COEFS_PER_SECTION*MAX_SECTIONS)-1:0] coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] filtered_sample
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic [cbq_pkg::SECTION_CFG_BITS-1:0] sections;
    logic signed [COEF_BITS-1:0]          gain;
    cbq_pkg::cbq_cmd_t                    cmd;
    logic [SEC_W-1:0]                     sec;
    logic                                 out_busy;

    cbq_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sections  (sections),
        .gain      (gain)
    );

    cbq_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .sections (sections),
        .out_busy (out_busy),
        .cmd      (cmd),
        .sec      (sec)
    );

    cbq_dp #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sec             (sec),
        .sample          (sample),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .gain            (gain),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .out_busy        (out_busy),
        .filtered_sample (filtered_sample)
    );

endmodule

[design/cbq_regs.sv]
// ----------------------------------------------------------------------------
// cbq_regs: configuration registers
// Holds the number of sections in use and the output gain.
// ----------------------------------------------------------------------------
module cbq_regs #(
    parameter int COEF_BITS = cbq_pkg::DEF_COEF_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_BITS-1:0]                 cfg_data,
    output logic [cbq_pkg::SECTION_CFG_BITS-1:0] sections,
    output logic signed [COEF_BITS-1:0]          gain
);

    localparam int GAIN_FRAC = COEF_BITS - cbq_pkg::COEF_INT_BITS;

    logic [cbq_pkg::SECTION_CFG_BITS-1:0] sections_reg;
    logic signed [COEF_BITS-1:0]          gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sections_reg <= cbq_pkg::SECTION_CFG_BITS'(1);
            // A gain of 1.0 in the coefficient format.
            gain_reg     <= COEF_BITS'(1) << GAIN_FRAC;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cbq_pkg::CFG_SECTIONS)
            begin
                sections_reg <= cfg_data[cbq_pkg::SECTION_CFG_BITS-1:0];
            end
            else if (cfg_index == cbq_pkg::CFG_GAIN)
            begin
                gain_reg <= cfg_data;
            end
        end
    end

    assign sections = sections_reg;
    assign gain     = gain_reg;

endmodule

[design/cbq_ctrl.sv]
// ----------------------------------------------------------------------------
// cbq_ctrl: sequencer of the biquad cascade
// Walks each sample through the sections in use, five steps per section,
// then applies the gain and hands the word to the output register.
// ----------------------------------------------------------------------------
module cbq_ctrl #(
    parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS,
    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [cbq_pkg::SECTION_CFG_BITS-1:0] sections,
    input  logic                                 out_busy,
    output cbq_pkg::cbq_cmd_t                    cmd,
    output logic [SEC_W-1:0]                     sec
);

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int NW    = (CNT_W > cbq_pkg::SECTION_CFG_BITS) ?
                           CNT_W : cbq_pkg::SECTION_CFG_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_WSUM = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_YSUM = 3'd5;
    localparam logic [2:0] ST_GMUL = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [NW-1:0]    n_req, n_max, n_eff;
    logic             accept, last_section;

    // A setting above the number of built sections is clamped.
    assign n_req        = NW'(sections);
    assign n_max        = NW'(MAX_SECTIONS);
    assign n_eff        = (n_req > n_max) ? n_max : n_req;
    assign last_section = (NW'(sec_reg) == (n_eff - NW'(1)));

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        cmd          = '0;
        cmd.coef_wr  = accept && mode;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !mode)
                begin
                    cmd.start  = 1'b1;
                    sec_next   = '0;
                    state_next = (n_eff == '0) ? ST_GMUL : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                cmd.wsum   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_YSUM;
            end
            ST_YSUM:
            begin
                cmd.ysum = 1'b1;
                if (last_section)
                begin
                    state_next = ST_GMUL;
                end
                else
                begin
                    sec_next   = sec_reg + SEC_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_GMUL:
            begin
                cmd.gmul   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Wait here while the previous word is still unclaimed.
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
        end
    end

    assign sec = sec_reg;

endmodule

[design/cbq_dp.sv]
// ----------------------------------------------------------------------------
// cbq_dp: datapath of the biquad cascade
// Coefficient memories, delay registers, the shared section arithmetic with
// rounding and saturation, the gain stage and the output register.
// ----------------------------------------------------------------------------
module cbq_dp #(
    parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS,
    parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS    = cbq_pkg::DEF_COEF_BITS,
    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
    localparam int IDX_W = $clog2(cbq_pkg::COEFS_PER_SECTION * MAX_SECTIONS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbq_pkg::cbq_cmd_t             cmd,
    input  logic [SEC_W-1:0]              sec,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [IDX_W-1:0]              coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    input  logic signed [COEF_BITS-1:0]   gain,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_busy,
    output logic signed [SAMPLE_BITS-1:0] filtered_sample
);

    localparam int NCOEF  = cbq_pkg::COEFS_PER_SECTION * MAX_SECTIONS;
    localparam int QW     = IDX_W - 2;
    localparam int D      = SAMPLE_BITS + cbq_pkg::DELAY_EXTRA_BITS;
    localparam int F      = COEF_BITS - cbq_pkg::COEF_INT_BITS;
    localparam int PW     = COEF_BITS + D;
    localparam int ACC_W  = PW + 2;
    localparam int OUT_W  = PW + 1;

    // ---------------- coefficient write address ----------------
    logic [IDX_W+7:0]          div_prod;
    logic [QW-1:0]             quot;
    logic [IDX_W-1:0]          quot5, rem;
    logic [cbq_pkg::SLOT_W-1:0] wslot;
    logic [SEC_W-1:0]          wsec;
    logic                      idx_ok;

    assign div_prod = (IDX_W+8)'(coef_index) * (IDX_W+8)'(cbq_pkg::DIV5_MUL);
    assign quot     = div_prod[cbq_pkg::DIV5_SHIFT +: QW];
    assign quot5    = {quot, 2'b00} + IDX_W'(quot);
    assign rem      = coef_index - quot5;
    assign wslot    = rem[cbq_pkg::SLOT_W-1:0];
    assign wsec     = quot[SEC_W-1:0];
    assign idx_ok   = (32'(coef_index) < 32'(NCOEF));

    // ---------------- coefficient memories, one per slot ----------------
    logic signed [COEF_BITS-1:0] coef_q [cbq_pkg::COEFS_PER_SECTION];

    for (genvar k = 0; k < cbq_pkg::COEFS_PER_SECTION; k++)
    begin : g_coef
        logic [COEF_BITS-1:0] mem [MAX_SECTIONS];

        always_ff @(posedge clk)
        begin
            if (cmd.coef_wr && idx_ok && (wslot == cbq_pkg::SLOT_W'(k)))
            begin
                mem[wsec] <= coef_value;
            end
            if (cmd.rd_en)
            begin
                coef_q[k] <= mem[sec];
            end
        end
    end

    // ---------------- rounding and saturation ----------------
    function automatic logic signed [D-1:0] rs_delay(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-D:0]        top;
        logic signed [D-1:0]     res;
        rnd = acc + {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
        sh  = rnd >>> F;
        top = sh[ACC_W-1:D-1];
        if ((&top) || !(|top))
        begin
            res = sh[D-1:0];
        end
        else if (sh[ACC_W-1])
        begin
            res = {1'b1, {(D-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(D-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rs_out(
        input logic signed [OUT_W-1:0] acc);
        logic signed [OUT_W-1:0]       rnd;
        logic signed [OUT_W-1:0]       sh;
        logic [OUT_W-SAMPLE_BITS:0]    top;
        logic signed [SAMPLE_BITS-1:0] res;
        rnd = acc + {{(OUT_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
        sh  = rnd >>> F;
        top = sh[OUT_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
        begin
            res = sh[SAMPLE_BITS-1:0];
        end
        else if (sh[OUT_W-1])
        begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // ---------------- delay registers ----------------
    logic signed [D-1:0] d1_reg [MAX_SECTIONS];
    logic signed [D-1:0] d2_reg [MAX_SECTIONS];

    // ---------------- section arithmetic ----------------
    logic signed [D-1:0]     x_reg, w1_reg, w2_reg, w_reg;
    logic signed [PW-1:0]    pa1_reg, pa2_reg, pb0_reg, pb1_reg, pb2_reg, pg_reg;
    logic signed [ACC_W-1:0] w_acc, y_acc;
    logic signed [D-1:0]     w_new, y_new;

    assign w_acc = {{(ACC_W-D-F){x_reg[D-1]}}, x_reg, {F{1'b0}}}
                 - {{2{pa1_reg[PW-1]}}, pa1_reg}
                 - {{2{pa2_reg[PW-1]}}, pa2_reg};
    assign y_acc = {{2{pb0_reg[PW-1]}}, pb0_reg}
                 + {{2{pb1_reg[PW-1]}}, pb1_reg}
                 + {{2{pb2_reg[PW-1]}}, pb2_reg};
    assign w_new = rs_delay(w_acc);
    assign y_new = rs_delay(y_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (cmd.wsum)
        begin
            d1_reg[sec] <= w_new;
            d2_reg[sec] <= w1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= {{(D-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        end
        else if (cmd.ysum)
        begin
            x_reg <= y_new;
        end
        if (cmd.rd_en)
        begin
            w1_reg <= d1_reg[sec];
            w2_reg <= d2_reg[sec];
        end
        if (cmd.mul1)
        begin
            pa1_reg <= coef_q[cbq_pkg::SLOT_A1] * w1_reg;
            pa2_reg <= coef_q[cbq_pkg::SLOT_A2] * w2_reg;
            pb1_reg <= coef_q[cbq_pkg::SLOT_B1] * w1_reg;
            pb2_reg <= coef_q[cbq_pkg::SLOT_B2] * w2_reg;
        end
        if (cmd.wsum)
        begin
            w_reg <= w_new;
        end
        if (cmd.mul2)
        begin
            pb0_reg <= coef_q[cbq_pkg::SLOT_B0] * w_reg;
        end
        if (cmd.gmul)
        begin
            pg_reg <= gain * x_reg;
        end
    end

    // ---------------- output register ----------------
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= rs_out({pg_reg[PW-1], pg_reg});
        end
    end

    assign out_busy        = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;

endmodule

[design/cbq_checker.sv]
// ----------------------------------------------------------------------------
// cbq_checker: port-level checks of the biquad cascade
// Watches the handshakes of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module cbq_checker #(
    parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS,
    parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS    = cbq_pkg::DEF_COEF_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          mode,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic [$clog2(cbq_pkg::COEFS_PER_SECTION*MAX_SECTIONS)-1:0] coef_index,
    input logic signed [COEF_BITS-1:0]   coef_value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] filtered_sample
);

    // A word offered at the input holds still until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(sample)
            && $stable(coef_index) && $stable(coef_value))
        else $error("input word changed or dropped before it was taken");

    // A word waiting at the output keeps its value until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_sample))
        else $error("output word changed or dropped while stalled");

    // A sample occupies the block, so the input closes after it.
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode |=> !in_ready)
        else $error("input still open right after a sample word");

    // A coefficient word finishes at once and leaves the input open.
    a_coef_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> in_ready)
        else $error("coefficient word held the input closed");

    // Nothing is offered at the output while reset is applied.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind cascaded_biquad_iir_filter cbq_checker #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COEF_BITS    (COEF_BITS)
) u_cbq_checker (.*);
